>>> rtl/core/epg_pkg.sv
// Shared types, constants and table-building functions for the portamento glide.
// No dependencies; used by every module of the block.
package epg_pkg;

  localparam int FREQ_BITS_DEF  = 24;
  localparam int COUNT_BITS_DEF = 20;
  localparam int EXP_DEPTH_DEF  = 256;

  localparam int ENV_W      = 16;
  localparam int CFG_DATA_W = 32;
  localparam int LOG_INT_W  = 5;
  localparam int LOG_FRAC_W = 16;
  localparam int LOG_W      = LOG_INT_W + LOG_FRAC_W;
  localparam int TAB_W      = 32;

  localparam logic [ENV_W-1:0] ENV_THR_RESET = 16'd1638;

  typedef enum logic [1:0] {
    CFG_GLIDE_SAMPLES = 2'd0,
    CFG_GLIDE_ALLOWED = 2'd1,
    CFG_ENV_THRESHOLD = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic load;
    logic start;
    logic iter;
    logic mul;
    logic sum;
    logic tab;
    logic fin;
    logic out_load;
  } epg_cmd_t;

  typedef struct packed {
    logic active;
  } epg_status_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (b > v) b = b >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // 2^(q/65536) in Q1.30 from a product of successive square roots of two
  function automatic logic [TAB_W-1:0] exp_frac(input logic [16:0] q);
    logic [63:0] rt [17];
    logic [63:0] m;
    rt[0] = 64'd1 << 31;
    for (int k = 1; k <= 16; k++) rt[k] = isqrt64(rt[k-1] << 30);
    m = 64'd1 << 30;
    if (q >= 17'd65536) return TAB_W'(64'd1 << 31);
    for (int k = 1; k <= 16; k++) begin
      if (q[16-k]) m = (m * rt[k] + (64'd1 << 29)) >> 30;
    end
    return TAB_W'(m);
  endfunction

endpackage

>>> rtl/core/epg_log2.sv
// Iterative log2 unit: top-bit search on start, one mantissa squaring per step.
// Depends on epg_pkg.
module epg_log2 import epg_pkg::*; #(
  parameter int FREQ_BITS = FREQ_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 start,
  input  logic                 step,
  input  logic [FREQ_BITS-1:0] x,
  output logic [LOG_W-1:0]     result
);

  logic [LOG_INT_W-1:0]  msb;
  logic [LOG_INT_W-1:0]  msb_find;
  logic [LOG_FRAC_W-1:0] frac;
  logic [31:0]           mant;
  logic [63:0]           sq;
  logic [32:0]           sq_top;

  always_comb begin
    msb_find = '0;
    for (int i = 0; i < FREQ_BITS; i++) begin
      if (x[i]) msb_find = LOG_INT_W'(i);
    end
  end

  assign sq     = 64'(mant) * 64'(mant);
  assign sq_top = sq[63:31];

  always_ff @(posedge clk) begin
    if (start) begin
      msb  <= msb_find;
      frac <= '0;
      mant <= 32'(x) << (LOG_INT_W'(31) - msb_find);
    end else if (step) begin
      if (sq_top[32]) begin
        mant <= sq_top[32:1];
        frac <= {frac[LOG_FRAC_W-2:0], 1'b1};
      end else begin
        mant <= sq_top[31:0];
        frac <= {frac[LOG_FRAC_W-2:0], 1'b0};
      end
    end
  end

  assign result = {msb, frac};

endmodule

>>> rtl/core/epg_datapath.sv
// Datapath: config registers, glide state, progress divider, log2 units,
// interpolation multipliers, exp2 table and output register. Depends on epg_pkg, epg_log2.
module epg_datapath import epg_pkg::*; #(
  parameter int FREQ_BITS       = FREQ_BITS_DEF,
  parameter int COUNT_BITS      = COUNT_BITS_DEF,
  parameter int EXP_TABLE_DEPTH = EXP_DEPTH_DEF,
  parameter int IN_W            = 48,
  parameter int OUT_W           = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  epg_cmd_t              cmd,
  output epg_status_t           status,
  input  logic [IN_W-1:0]       in_data,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [OUT_W-1:0]      out_data
);

  localparam int DW     = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int EP_W   = LOG_W + 18;
  localparam int LP_W   = FREQ_BITS + 18;
  localparam logic [FREQ_BITS-1:0] FMAX = '1;

  logic [TAB_W-1:0] exp_tab [EXP_TABLE_DEPTH+1];

  for (genvar j = 0; j < EXP_TABLE_DEPTH; j++) begin : g_tab
    localparam logic [16:0] QV = 17'((j * 65536) / EXP_TABLE_DEPTH);
    localparam logic [TAB_W-1:0] ENTRY = exp_frac(QV);
    assign exp_tab[j] = ENTRY;
  end
  assign exp_tab[EXP_TABLE_DEPTH] = TAB_W'(64'd1 << 31);

  // configuration
  logic [COUNT_BITS-1:0] glide_samples;
  logic                  glide_allowed;
  logic [ENV_W-1:0]      env_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      glide_samples <= '0;
      glide_allowed <= 1'b0;
      env_threshold <= ENV_THR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GLIDE_SAMPLES: glide_samples <= cfg_data[COUNT_BITS-1:0];
        CFG_GLIDE_ALLOWED: glide_allowed <= cfg_data[0];
        CFG_ENV_THRESHOLD: env_threshold <= cfg_data[ENV_W-1:0];
        default: ;
      endcase
    end
  end

  // glide state
  logic [FREQ_BITS-1:0]  current_freq, current_freq_next;
  logic [FREQ_BITS-1:0]  glide_from, glide_from_next;
  logic [FREQ_BITS-1:0]  glide_to, glide_to_next;
  logic [COUNT_BITS-1:0] samples_left, samples_left_next;
  logic [COUNT_BITS-1:0] glide_length, glide_length_next;

  logic [FREQ_BITS-1:0] in_target;
  logic                 in_gate;
  logic [ENV_W-1:0]     in_env;

  assign in_target = in_data[FREQ_BITS-1:0];
  assign in_gate   = in_data[FREQ_BITS];
  assign in_env    = in_data[FREQ_BITS+ENV_W:FREQ_BITS+1];

  // divider and product registers
  logic [COUNT_BITS:0]         rem;
  logic [COUNT_BITS:0]         rem_sh;
  logic [LOG_FRAC_W-1:0]       quot;
  logic                        p_bad;
  logic [LOG_FRAC_W-1:0]       prog;
  logic [LOG_W-1:0]            log_from, log_to;
  logic signed [EP_W-1:0]      exp_prod;
  logic signed [LP_W-1:0]      lin_prod;
  logic signed [EP_W-1:0]      e_full;
  logic [LOG_W-1:0]            e_val;
  logic [LOG_FRAC_W+DW-1:0]    s_val;
  logic [DW-1:0]               tj;
  logic [LOG_FRAC_W-1:0]       tr;
  logic [LOG_INT_W-1:0]        ei;
  logic signed [LP_W-1:0]      lin_full;
  logic [FREQ_BITS-1:0]        lin_val;
  logic [TAB_W-1:0]            t0, t1;
  logic [TAB_W+LOG_FRAC_W-1:0] t_prod;
  logic [TAB_W-1:0]            tval;
  logic [63:0]                 shifted;
  logic [33:0]                 code;
  logic [FREQ_BITS-1:0]        exp_code;
  logic [FREQ_BITS-1:0]        glide_freq;
  logic [COUNT_BITS-1:0]       left_dec;

  epg_log2 #(.FREQ_BITS(FREQ_BITS)) u_log_from (
    .clk(clk), .start(cmd.start), .step(cmd.iter), .x(glide_from), .result(log_from)
  );
  epg_log2 #(.FREQ_BITS(FREQ_BITS)) u_log_to (
    .clk(clk), .start(cmd.start), .step(cmd.iter), .x(glide_to), .result(log_to)
  );

  always_comb begin
    current_freq_next = current_freq;
    glide_from_next   = glide_from;
    glide_to_next     = glide_to;
    samples_left_next = samples_left;
    glide_length_next = glide_length;
    if (!glide_allowed || glide_samples == '0) begin
      current_freq_next = in_target;
      glide_to_next     = in_target;
      samples_left_next = '0;
    end else if (in_target != glide_to) begin
      if (in_gate && in_env > env_threshold && current_freq != '0) begin
        glide_from_next   = current_freq;
        glide_to_next     = in_target;
        glide_length_next = glide_samples;
        samples_left_next = glide_samples;
      end else begin
        current_freq_next = in_target;
        glide_to_next     = in_target;
        samples_left_next = '0;
      end
    end
  end

  assign rem_sh = {rem[COUNT_BITS-1:0], 1'b0};
  assign prog   = p_bad ? '0 : quot;

  assign e_full = $signed({{(EP_W-LOG_W){1'b0}}, log_from}) + (exp_prod >>> LOG_FRAC_W);
  assign e_val  = e_full[EP_W-1] ? '0 : e_full[LOG_W-1:0];
  assign s_val  = (LOG_FRAC_W+DW)'(e_val[LOG_FRAC_W-1:0]) * (LOG_FRAC_W+DW)'(EXP_TABLE_DEPTH);

  assign lin_full = $signed({{(LP_W-FREQ_BITS){1'b0}}, glide_from}) + (lin_prod >>> LOG_FRAC_W);

  assign t0     = exp_tab[tj];
  assign t1     = exp_tab[tj + DW'(1)];
  assign t_prod = (TAB_W+LOG_FRAC_W)'(t1 - t0) * (TAB_W+LOG_FRAC_W)'(tr);

  assign shifted  = 64'(tval) << ei;
  assign code     = 34'((shifted + (64'd1 << 29)) >> 30);
  assign exp_code = (code > 34'(FMAX)) ? FMAX : code[FREQ_BITS-1:0];

  assign glide_freq = (glide_from != '0 && glide_to != '0) ? exp_code : lin_val;
  assign left_dec   = samples_left - COUNT_BITS'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      current_freq <= '0;
      glide_from   <= '0;
      glide_to     <= '0;
      samples_left <= '0;
      glide_length <= '0;
    end else if (cmd.load) begin
      current_freq <= current_freq_next;
      glide_from   <= glide_from_next;
      glide_to     <= glide_to_next;
      samples_left <= samples_left_next;
      glide_length <= glide_length_next;
    end else if (cmd.fin) begin
      samples_left <= left_dec;
      current_freq <= (left_dec == '0) ? glide_to : glide_freq;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem   <= {1'b0, glide_length - samples_left};
      p_bad <= (glide_length == '0) || (samples_left > glide_length);
      quot  <= '0;
    end else if (cmd.iter) begin
      if (rem_sh >= {1'b0, glide_length}) begin
        rem  <= rem_sh - {1'b0, glide_length};
        quot <= {quot[LOG_FRAC_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        quot <= {quot[LOG_FRAC_W-2:0], 1'b0};
      end
    end
    if (cmd.mul) begin
      exp_prod <= EP_W'($signed({1'b0, log_to}) - $signed({1'b0, log_from}))
                  * EP_W'($signed({1'b0, prog}));
      lin_prod <= LP_W'($signed({1'b0, glide_to}) - $signed({1'b0, glide_from}))
                  * LP_W'($signed({1'b0, prog}));
    end
    if (cmd.sum) begin
      tj <= s_val[LOG_FRAC_W+DW-1:LOG_FRAC_W];
      tr <= s_val[LOG_FRAC_W-1:0];
      ei <= e_val[LOG_W-1:LOG_FRAC_W];
      if (lin_full < 0) lin_val <= '0;
      else if (lin_full > $signed(LP_W'(FMAX))) lin_val <= FMAX;
      else lin_val <= lin_full[FREQ_BITS-1:0];
    end
    if (cmd.tab) begin
      tval <= t0 + t_prod[TAB_W+LOG_FRAC_W-1:LOG_FRAC_W];
    end
    if (cmd.out_load) begin
      out_data <= OUT_W'({samples_left != '0, current_freq});
    end
  end

  assign status.active = (samples_left != '0);

endmodule

>>> rtl/core/epg_ctrl.sv
// Sequencer: steps each item through load and, during a glide, divide/log iterations and the
// interpolation stages, and owns the output valid. Depends on epg_pkg.
module epg_ctrl import epg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  epg_status_t status,
  output epg_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_ITER, ST_MUL, ST_SUM, ST_TAB, ST_FIN, ST_OUT
  } state_t;

  state_t                  state;
  logic [LOG_FRAC_W/4-1:0] iter_cnt;
  logic                    out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.load     = (state == ST_IDLE) && in_valid;
    cmd.start    = (state == ST_LOAD) && status.active;
    cmd.iter     = (state == ST_ITER);
    cmd.mul      = (state == ST_MUL);
    cmd.sum      = (state == ST_SUM);
    cmd.tab      = (state == ST_TAB);
    cmd.fin      = (state == ST_FIN);
    cmd.out_load = (state == ST_OUT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      iter_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: if (in_valid) state <= ST_LOAD;
        ST_LOAD: begin
          iter_cnt <= '0;
          state    <= status.active ? ST_ITER : ST_OUT;
        end
        ST_ITER: begin
          iter_cnt <= iter_cnt + 1'b1;
          if (iter_cnt == '1) state <= ST_MUL;
        end
        ST_MUL:  state <= ST_SUM;
        ST_SUM:  state <= ST_TAB;
        ST_TAB:  state <= ST_FIN;
        ST_FIN:  state <= ST_OUT;
        ST_OUT:  if (out_free) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/exponential_portamento_glide.sv
// Exponential portamento glide, top level. When the pitch jumps or holds, an item
// goes from LOAD straight to OUT; during a glide it passes the ITER states, shared
// by the progress divider and log2 squaring iterations, then MUL, SUM, TAB and FIN.
// One item at a time; a finished item may wait in the output register meanwhile.
// Synchronous reset clears glide state and config (threshold to 1638); no clearing pass.
module exponential_portamento_glide import epg_pkg::*; #(
  parameter int FREQ_BITS       = FREQ_BITS_DEF,
  parameter int COUNT_BITS      = COUNT_BITS_DEF,
  parameter int EXP_TABLE_DEPTH = EXP_DEPTH_DEF,
  localparam int IN_W  = ((FREQ_BITS + 1 + ENV_W + 7) / 8) * 8,
  localparam int OUT_W = ((FREQ_BITS + 1 + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_W-1:0]       s_tdata,   // target_freq, gate_on, env_level
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_W-1:0]      m_tdata,   // play_freq, gliding
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  epg_cmd_t    cmd;
  epg_status_t status;

  assign cfg_ready = 1'b1;

  epg_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .status(status), .cmd(cmd)
  );

  epg_datapath #(
    .FREQ_BITS(FREQ_BITS), .COUNT_BITS(COUNT_BITS),
    .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH), .IN_W(IN_W), .OUT_W(OUT_W)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .in_data(s_tdata), .cfg_we(cfg_valid), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .out_data(m_tdata)
  );

endmodule

>>> rtl/core/epg_checker.sv
// Port-level checks for the portamento glide, bound to the top level.
// Depends on epg_pkg and exponential_portamento_glide.
module epg_checker import epg_pkg::*; #(
  parameter int OUT_W = 32
) (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata,
  input logic             cfg_valid,
  input logic             cfg_ready
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second item accepted while one is in work");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled output item changed");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("config write stalled");

endmodule

bind exponential_portamento_glide epg_checker #(.OUT_W(OUT_W)) u_epg_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
  .cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
);
